[rtl/core/stpq_pkg.sv]
// Shared types and codes for the sorted task priority queue.
package stpq_pkg;
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_OUT  = 2'd2
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture input beat
		logic exec;   // search results registered; update array and result
	} dp_cmd_t;
endpackage

[rtl/core/sorted_task_priority_queue.sv]
// Sorted task priority queue: highest priority first, new task ahead of equals.
// A beat's compares are registered, the queue updates at execute, and the
// result is held until drained; the next beat waits for idle or for that drain.
// Reset (arst_n, async low) empties the queue; entry contents are not cleared.
// Head and occupancy come straight from cell 0 and the count; status, found and
// removed priority are registered at execute.
module sorted_task_priority_queue import stpq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] task_id,
	input  logic [7:0]  priority_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        found,
	output logic [7:0]  removed_priority,
	output logic [15:0] head_task_id,
	output logic        head_valid,
	output logic [4:0]  occupancy
);
	dp_cmd_t dcmd;

	// sequencer: idle -> execute -> hold result
	stpq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(dcmd)
	);

	// entry cells with parallel id/priority compares
	stpq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(dcmd),
		.command(command), .task_id(task_id), .priority_req(priority_req),
		.status(status), .found(found), .removed_priority(removed_priority),
		.head_task_id(head_task_id), .head_valid(head_valid),
		.occupancy(occupancy)
	);

	// queue never exceeds its depth
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= 5'(QUEUE_DEPTH)) else $error("occupancy overflow");
	// a full report comes only with occupancy at the depth
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> occupancy == 5'(QUEUE_DEPTH))
		else $error("full status with room");
	// a removal reports that the task was present
	a_rm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && removed_priority != 8'd0 |-> found)
		else $error("removed priority without match");
	// no input beat taken while an execute is in flight
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("overlapping commands");
endmodule

[rtl/core/stpq_ctrl.sv]
// Controller state machine for the sorted task priority queue.
module stpq_ctrl import stpq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);
	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_next = S_EXEC;
			S_EXEC: state_next = S_OUT;
			S_OUT: begin
				if (out_ready) state_next = in_valid ? S_EXEC : S_IDLE;
			end
			default: state_next = S_IDLE;
		endcase
	end

	// next beat is taken in the same cycle the result drains
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_EXEC: cmd.exec = 1'b1;
			S_OUT: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
			end
			default: ;
		endcase
		cmd.load = in_valid & in_ready;
	end
endmodule

[rtl/core/stpq_dp.sv]
// Datapath: sorted entry cells, per-cell compares, shift update, result register.
module stpq_dp import stpq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [1:0]  command,
	input  logic [15:0] task_id,
	input  logic [7:0]  priority_req,
	output logic [1:0]  status,
	output logic        found,
	output logic [7:0]  removed_priority,
	output logic [15:0] head_task_id,
	output logic        head_valid,
	output logic [4:0]  occupancy
);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [15:0]  ids_q [QUEUE_DEPTH];
	logic [7:0]   pri_q [QUEUE_DEPTH];
	logic [CW-1:0] count_q;

	logic [1:0]  cmd_s1;
	logic [15:0] id_s1;
	logic [7:0]  pri_s1;

	// per-cell compare vectors, registered
	logic [QUEUE_DEPTH-1:0] match_s2, gt_s2;
	logic [QUEUE_DEPTH-1:0] match_c, gt_c, first_c, rm_c;
	logic [QUEUE_DEPTH-1:0] valid_c;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_s1 <= command;
			id_s1  <= task_id;
			pri_s1 <= priority_req;
		end
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			valid_c[i] = (CW'(i) < count_q);
			match_c[i] = valid_c[i] && (ids_q[i] == task_id);
			gt_c[i]    = valid_c[i] && (pri_q[i] > priority_req);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			match_s2 <= match_c;
			gt_s2    <= gt_c;
		end
	end

	// lowest matching cell; cells at or after it shift toward cell 0 on remove
	always_comb begin
		first_c = match_s2 & (~match_s2 + 1'b1);
		rm_c    = ~(first_c - 1'b1) & {QUEUE_DEPTH{|match_s2}};
	end

	logic any_match, full, do_ins, do_rm;
	logic [7:0] rm_pri;
	always_comb begin
		any_match = |match_s2;
		full      = (count_q >= CW'(QUEUE_DEPTH));
		do_ins    = (cmd_s1 == CMD_INSERT) && !full;
		do_rm     = (cmd_s1 == CMD_REMOVE) && any_match;
		rm_pri    = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++)
			if (first_c[i]) rm_pri = pri_q[i];
	end

	// gt_s2 is a prefix of ones; insert slot is its first zero
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (do_ins) begin
					if (!gt_s2[i]) begin
						if (i == 0 || gt_s2[(i+QUEUE_DEPTH-1) % QUEUE_DEPTH]) begin
							ids_q[i] <= id_s1;
							pri_q[i] <= pri_s1;
						end else begin
							ids_q[i] <= ids_q[(i+QUEUE_DEPTH-1) % QUEUE_DEPTH];
							pri_q[i] <= pri_q[(i+QUEUE_DEPTH-1) % QUEUE_DEPTH];
						end
					end
				end else if (do_rm && rm_c[i] && i < QUEUE_DEPTH - 1) begin
					ids_q[i] <= ids_q[(i+1) % QUEUE_DEPTH];
					pri_q[i] <= pri_q[(i+1) % QUEUE_DEPTH];
				end
			end
		end
	end

	logic [CW-1:0] count_next;
	always_comb begin
		count_next = count_q;
		if (do_ins) count_next = count_q + 1'b1;
		else if (do_rm) count_next = count_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cmd.exec) count_q <= count_next;
	end

	status_t st_c;
	always_comb begin
		st_c = ST_DONE;
		case (cmd_s1)
			CMD_INSERT: if (full) st_c = ST_FULL;
			CMD_REMOVE, CMD_QUERY: if (!any_match) st_c = ST_NOT_FOUND;
			default: st_c = ST_DONE;
		endcase
	end

	logic [1:0] status_q;
	logic       found_q;
	logic [7:0] rmp_q;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= st_c;
			found_q  <= any_match;
			rmp_q    <= do_rm ? rm_pri : 8'd0;
		end
	end

	logic [IW-1:0] unused_ix;
	assign unused_ix = '0;

	assign status           = status_q;
	assign found            = found_q;
	assign removed_priority = rmp_q;
	assign head_valid       = (count_q != '0);
	assign head_task_id     = head_valid ? ids_q[unused_ix] : 16'd0;
	assign occupancy        = 5'(count_q);
endmodule

[sim/stpq_checker.sv]
// Checker: predicts sorted-queue results from accepted commands and compares them.
module stpq_checker import stpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] task_id,
	input  logic [7:0]  priority_req,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic        found,
	input  logic [7:0]  removed_priority,
	input  logic [15:0] head_task_id,
	input  logic        head_valid,
	input  logic [4:0]  occupancy,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [7:0]  removed_priority;
		logic [15:0] head_task_id;
		logic        head_valid;
		logic [4:0]  occupancy;
	} queue_result_t;

	logic [15:0] q_ids [DEPTH];
	logic [7:0]  q_prios [DEPTH];
	int          q_count;
	queue_result_t result_fifo [$];

	function automatic queue_result_t apply_command(cmd_t cmd, logic [15:0] id,
			logic [7:0] prio);
		queue_result_t r;
		int pos;
		int at;
		pos = -1;
		for (int i = 0; i < q_count; i++)
			if (pos < 0 && q_ids[i] == id) pos = i;
		r = '0;
		r.status = ST_DONE;
		r.found = (pos >= 0);
		case (cmd)
			CMD_INSERT: begin
				if (q_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					at = 0;
					while (at < q_count && q_prios[at] > prio) at++;
					for (int i = q_count; i > at; i--) begin
						q_ids[i] = q_ids[i-1];
						q_prios[i] = q_prios[i-1];
					end
					q_ids[at] = id;
					q_prios[at] = prio;
					q_count++;
				end
			end
			CMD_REMOVE: begin
				if (pos < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.removed_priority = q_prios[pos];
					for (int i = pos; i + 1 < q_count; i++) begin
						q_ids[i] = q_ids[i+1];
						q_prios[i] = q_prios[i+1];
					end
					q_count--;
				end
			end
			CMD_QUERY: if (pos < 0) r.status = ST_NOT_FOUND;
			default: ;
		endcase
		r.head_valid = (q_count > 0);
		r.head_task_id = (q_count > 0) ? q_ids[0] : 16'd0;
		r.occupancy = q_count[4:0];
		return r;
	endfunction

	assign pending = result_fifo.size();

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		queue_result_t got;
		if (!arst_n) begin
			q_count = 0;
			fail_count = 0;
			result_fifo.delete();
		end else begin
			if (out_valid && out_ready) begin
				got = '{status, found, removed_priority, head_task_id, head_valid,
					occupancy};
				if (result_fifo.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat %h", got);
				end else begin
					want = result_fifo.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: st %0d/%0d fnd %0d/%0d rp %0d/%0d hd %h/%h hv %0d/%0d occ %0d/%0d",
								want.status, got.status, want.found, got.found,
								want.removed_priority, got.removed_priority,
								want.head_task_id, got.head_task_id,
								want.head_valid, got.head_valid,
								want.occupancy, got.occupancy);
					end
				end
			end
			if (in_valid && in_ready)
				result_fifo.push_back(apply_command(cmd_t'(command), task_id, priority_req));
		end
	end

	// Leftover expectations are reported by the top, which sees pending.
endmodule

[sim/tb_sorted_task_priority_queue.sv]
// Testbench top: command stimulus, clock, reset and verdict for the task queue.
module tb_sorted_task_priority_queue import stpq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [15:0] task_id;
	logic [7:0]  priority_req;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic        found;
	logic [7:0]  removed_priority;
	logic [15:0] head_task_id;
	logic        head_valid;
	logic [4:0]  occupancy;
	int          fail_count;
	int          pending;

	// ids inserted so far; removes and queries mostly name one of these
	logic [15:0] live_ids [$];
	int          sent;
	bit          stim_done;

	sorted_task_priority_queue dut (.*);

	stpq_checker checker_i (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Drive one command beat; valid holds until the handshake edge.
	task automatic send_beat(cmd_t cmd, logic [15:0] id, logic [7:0] prio);
		in_valid <= 1'b1;
		command <= cmd;
		task_id <= id;
		priority_req <= prio;
		do @(posedge clk); while (!in_ready);
		if (cmd == CMD_INSERT) live_ids.push_back(id);
		sent++;
	endtask

	task automatic idle_gap(int n);
		if (n == 0) return;
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Random command: biased toward ids already seen so removes hit,
	// and insert-heavy or remove-heavy runs to sweep occupancy across full and empty.
	task automatic random_beat(int phase);
		cmd_t        cmd;
		logic [15:0] id;
		int          r;
		r = $urandom_range(0, 99);
		if (phase == 0) cmd = (r < 70) ? CMD_INSERT : (r < 90 ? CMD_REMOVE : CMD_QUERY);
		else if (phase == 1) cmd = (r < 25) ? CMD_INSERT : (r < 80 ? CMD_REMOVE : CMD_QUERY);
		else cmd = (r < 40) ? CMD_INSERT : (r < 75 ? CMD_REMOVE : (r < 95 ? CMD_QUERY : CMD_NOP));
		if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
			id = live_ids[$urandom_range(0, live_ids.size() - 1)];
		else if ($urandom_range(0, 1))
			id = $urandom_range(0, 7);
		else
			id = $urandom;
		// narrow priorities produce many ties
		send_beat(cmd, id, $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_NOP;
		task_id = '0;
		priority_req = '0;
		sent = 0;
		stim_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-queue misses, extremes, tie order, full queue, duplicates.
		send_beat(CMD_REMOVE, 16'h0005, 8'h00);
		send_beat(CMD_QUERY, 16'hFFFF, 8'hFF);
		send_beat(CMD_NOP, 16'h0000, 8'h00);
		send_beat(CMD_INSERT, 16'hFFFF, 8'h00);
		send_beat(CMD_INSERT, 16'h0000, 8'hFF);
		send_beat(CMD_INSERT, 16'h1234, 8'h80);
		send_beat(CMD_INSERT, 16'h5555, 8'h80);  // ahead of the equal priority
		send_beat(CMD_INSERT, 16'h1234, 8'h01);  // duplicate id
		send_beat(CMD_QUERY, 16'h1234, 8'h00);
		send_beat(CMD_REMOVE, 16'h1234, 8'h00);  // nearest the head goes
		send_beat(CMD_NOP, 16'h5555, 8'hAA);
		for (int i = 0; i < 12; i++)
			send_beat(CMD_INSERT, 16'hAAAA ^ i[15:0], i[7:0]);
		send_beat(CMD_INSERT, 16'h7777, 8'h7F);  // full
		send_beat(CMD_REMOVE, 16'h0000, 8'h00);

		for (int n = 0; n < 900; n++) begin
			idle_gap(gap_len() * (((n / 100) % 3) != 2));
			random_beat((n / 40) % 3);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver stalls, with a stall-free stretch in each period.
	initial begin
		int r;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			r = $urandom_range(0, 299);
			if ((sent % 300) > 250) out_ready <= 1'b1;
			else if (r < 10) out_ready <= 1'b0;
			else if (r < 80) out_ready <= ($urandom_range(0, 1) == 1);
			else out_ready <= 1'b1;
		end
	end

	initial begin
		@(posedge arst_n);
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end
endmodule

[sorted_task_priority_queue.f]
rtl/core/stpq_pkg.sv
rtl/core/stpq_ctrl.sv
rtl/core/stpq_dp.sv
rtl/core/sorted_task_priority_queue.sv
sim/stpq_checker.sv
sim/tb_sorted_task_priority_queue.sv
